### rtl/assert_macros.svh
// Assertion macros for the RTL of the line matcher; regex_line_match uses them.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RLM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line matcher check failed");

// Next-cycle implication, disabled while reset is high.
`define RLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line matcher check failed");

`endif

### rtl/rlm_pkg.sv
// Types and constants for the line matcher: payload structs, register indexes,
// per-atom cell configuration. No dependencies.
`default_nettype none

package rlm_pkg;

   localparam int RLM_MAX_ATOMS = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int CHAR_W        = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHARS_LO    = 3'd0,
      CSR_CHARS_HI    = 3'd1,
      CSR_IS_ANY      = 3'd2,
      CSR_ATOM_COUNT  = 3'd3,
      CSR_ANCHORED    = 3'd4,
      CSR_REPEAT_KIND = 3'd5,
      CSR_REPEAT_ATOM = 3'd6
   } rlm_csr_idx_type;

   typedef enum logic [1:0] {
      REP_NONE = 2'd0,
      REP_OPT  = 2'd1,
      REP_STAR = 2'd2,
      REP_PLUS = 2'd3
   } rlm_rep_type;

   typedef enum logic {
      FUNC_CHAR = 1'b0,
      FUNC_EOL  = 1'b1
   } rlm_func_type;

   typedef struct packed {
      logic              func;
      logic [CHAR_W-1:0] text_char;
   } rlm_req_type;

   typedef struct packed {
      logic line_matched;
   } rlm_rsp_type;

   // Decoded setup of one atom, as seen by its cell.
   typedef struct packed {
      logic [CHAR_W-1:0] lit;
      logic              is_any;
      logic              active;   // atom lies inside the pattern
      logic              skip;     // quantified and may be skipped
      logic              loop;     // quantified, zero or more
      logic              plus;     // quantified, one or more
   } rlm_atom_cfg_type;

   // Line-level control handed to every cell.
   typedef struct packed {
      logic advance;
      logic clear;
   } rlm_step_type;

endpackage

`default_nettype wire

### rtl/rlm_stream_ifs.sv
// Request and response channel interfaces of the line matcher.
// Depends on rlm_pkg for the payload structs.
`default_nettype none

interface rlm_req_if;
   logic                valid;
   logic                ready;
   rlm_pkg::rlm_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rlm_rsp_if;
   logic                valid;
   logic                ready;
   rlm_pkg::rlm_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/regex_line_match.sv
// Line matcher: takes one request per clock, text byte or end of line, with no
// stall of its own; a request is refused only while an unread line result sits
// in the output register. Every pattern position advances at once in a row of
// MAX_ATOMS cells, so the sustained rate is one request per cycle and the line
// result appears the cycle after the end-of-line request. The longest path runs
// from the text byte through one cell compare and the skip ripple along the row.
// Depends on rlm_pkg, rlm_stream_ifs, rlm_csr, rlm_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module regex_line_match #(
   parameter int MAX_ATOMS = rlm_pkg::RLM_MAX_ATOMS
) (
   input  wire                            clock,
   input  wire                            reset,
   rlm_req_if.sink                        req,
   rlm_rsp_if.source                      rsp,
   input  wire                            csr_write_en,
   input  wire [rlm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [rlm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rlm_pkg::*;

   localparam int NW = $clog2(MAX_ATOMS + 1);

   rlm_atom_cfg_type atom_cfg [MAX_ATOMS];
   logic [NW-1:0]    pat_len;
   logic             anchored;

   logic live0_ff, live0_in;
   logic match_seen_ff, match_seen_in;
   logic at_line_start_ff, at_line_start_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_match_ff, rsp_match_in;

   logic [MAX_ATOMS:0]   cur_vec;
   logic [MAX_ATOMS:0]   nxt_vec;
   logic [MAX_ATOMS:0]   loop_vec;
   logic                 req_fire;
   logic                 is_eol;
   logic                 cur_end;
   logic                 nxt_end;
   rlm_step_type         step;

   rlm_csr #(.MAX_ATOMS(MAX_ATOMS), .NW(NW)) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .atom_cfg     (atom_cfg),
      .pat_len      (pat_len),
      .anchored     (anchored)
   );

   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign req_fire  = req.valid & req.ready;
   assign is_eol    = (rlm_func_type'(req.data.func) == FUNC_EOL);

   assign step.clear   = req_fire & is_eol;
   assign step.advance = req_fire & ~is_eol;

   // start position is live every byte unless anchored past line start, where only a loop on atom 0 keeps it live
   assign cur_vec[0]         = live0_ff | ~anchored | at_line_start_ff;
   assign nxt_vec[0]         = loop_vec[0];
   assign loop_vec[MAX_ATOMS] = 1'b0;

   for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
      rlm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .cfg       (atom_cfg[i]),
         .text_char (req.data.text_char),
         .cur_in    (cur_vec[i]),
         .nxt_in    (nxt_vec[i]),
         .loop_in   (loop_vec[i+1]),
         .cur_out   (cur_vec[i+1]),
         .nxt_out   (nxt_vec[i+1]),
         .loop_out  (loop_vec[i])
      );
   end

   assign cur_end = cur_vec[pat_len];
   assign nxt_end = nxt_vec[pat_len];

   always_comb begin
      live0_in         = live0_ff;
      match_seen_in    = match_seen_ff;
      at_line_start_in = at_line_start_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp.ready;
      rsp_match_in     = rsp_match_ff;
      if (step.clear) begin
         // report and drop the line state
         live0_in         = 1'b1;
         match_seen_in    = 1'b0;
         at_line_start_in = 1'b1;
         rsp_valid_in     = 1'b1;
         rsp_match_in     = match_seen_ff | cur_end;
      end else if (step.advance) begin
         live0_in         = nxt_vec[0];
         match_seen_in    = match_seen_ff | cur_end | nxt_end;
         at_line_start_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live0_ff         <= 1'b1;
         match_seen_ff    <= 1'b0;
         at_line_start_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         live0_ff         <= live0_in;
         match_seen_ff    <= match_seen_in;
         at_line_start_ff <= at_line_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.data.line_matched = rsp_match_ff;

   `RLM_ASSERT_SAME(a_rsp_from_eol, clock, reset, $rose(rsp_valid_ff), $past(step.clear))
   `RLM_ASSERT_NEXT(a_eol_clears, clock, reset, step.clear,
      at_line_start_ff && !match_seen_ff && live0_ff && rsp_valid_ff)
   `RLM_ASSERT_NEXT(a_char_leaves_start, clock, reset, step.advance, !at_line_start_ff)
   `RLM_ASSERT_SAME(a_no_fire_when_full, clock, reset, rsp_valid_ff && !rsp.ready,
      !req.ready)

endmodule

`default_nettype wire

### rtl/rlm_cell.sv
// One matcher cell: checks its atom against the text byte and holds the live
// bit of the position just past the atom. Depends on rlm_pkg.
`default_nettype none

module rlm_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  rlm_pkg::rlm_step_type     step,
   input  rlm_pkg::rlm_atom_cfg_type cfg,
   input  wire [rlm_pkg::CHAR_W-1:0] text_char,
   input  wire                       cur_in,
   input  wire                       nxt_in,
   input  wire                       loop_in,
   output logic                      cur_out,
   output logic                      nxt_out,
   output logic                      loop_out
);
   import rlm_pkg::*;

   logic live_ff;
   logic live_in;
   logic hit;
   logic step_hit;

   assign hit = cfg.is_any | (cfg.lit == text_char);

   // entry set: skipping the quantified atom makes the next position live
   assign cur_out  = live_ff | (cfg.skip & cur_in);
   assign step_hit = cfg.active & hit & (cur_in | (cfg.plus & cur_out));
   assign loop_out = cfg.loop & hit & cur_in;
   assign nxt_out  = step_hit | loop_in | (cfg.skip & nxt_in);

   always_comb begin
      live_in = live_ff;
      if (step.clear) begin
         live_in = 1'b0;
      end else if (step.advance) begin
         live_in = nxt_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rlm_csr.sv
// Pattern registers of the line matcher and their decode into per-atom cell
// setup, pattern length and anchor. Depends on rlm_pkg.
`default_nettype none

module rlm_csr #(
   parameter int MAX_ATOMS = rlm_pkg::RLM_MAX_ATOMS,
   parameter int NW        = $clog2(MAX_ATOMS + 1)
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_en,
   input  wire [rlm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [rlm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rlm_pkg::rlm_atom_cfg_type      atom_cfg [MAX_ATOMS],
   output logic [NW-1:0]                  pat_len,
   output logic                           anchored
);
   import rlm_pkg::*;

   localparam int CntW = (NW > 5) ? NW : 5;

   logic [63:0] chars_lo_ff, chars_hi_ff;
   logic [15:0] is_any_ff;
   logic [4:0]  count_ff;
   logic        anchored_ff;
   logic [1:0]  kind_ff;
   logic [3:0]  ratom_ff;

   logic [CntW-1:0] count_wide;
   logic [CntW-1:0] len_wide;
   logic [CntW-1:0] ratom_wide;
   logic            q_valid;
   logic            skip_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_lo_ff <= '0;
         chars_hi_ff <= '0;
         is_any_ff   <= '0;
         count_ff    <= '0;
         anchored_ff <= 1'b0;
         kind_ff     <= '0;
         ratom_ff    <= '0;
      end else if (csr_write_en) begin
         case (rlm_csr_idx_type'(csr_index))
            CSR_CHARS_LO:    chars_lo_ff <= csr_wdata;
            CSR_CHARS_HI:    chars_hi_ff <= csr_wdata;
            CSR_IS_ANY:      is_any_ff   <= csr_wdata[15:0];
            CSR_ATOM_COUNT:  count_ff    <= csr_wdata[4:0];
            CSR_ANCHORED:    anchored_ff <= csr_wdata[0];
            CSR_REPEAT_KIND: kind_ff     <= csr_wdata[1:0];
            CSR_REPEAT_ATOM: ratom_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // clamp the count to the cell row
   assign count_wide = CntW'(count_ff);
   assign len_wide   = (count_wide > CntW'(MAX_ATOMS)) ? CntW'(MAX_ATOMS) : count_wide;
   assign pat_len    = len_wide[NW-1:0];
   assign anchored   = anchored_ff;

   assign ratom_wide = CntW'(ratom_ff);
   assign q_valid    = (rlm_rep_type'(kind_ff) != REP_NONE) && (ratom_wide < len_wide);
   assign skip_kind  = (rlm_rep_type'(kind_ff) == REP_OPT) ||
                       (rlm_rep_type'(kind_ff) == REP_STAR);

   for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_atom
      logic is_q;
      assign is_q = q_valid && (ratom_wide == CntW'(i));

      if (i < 8) begin : g_lo
         assign atom_cfg[i].lit    = chars_lo_ff[8*i +: 8];
         assign atom_cfg[i].is_any = is_any_ff[i];
      end else if (i < 16) begin : g_hi
         assign atom_cfg[i].lit    = chars_hi_ff[8*(i-8) +: 8];
         assign atom_cfg[i].is_any = is_any_ff[i];
      end else begin : g_zero
         // atoms past the register file match only a zero byte
         assign atom_cfg[i].lit    = '0;
         assign atom_cfg[i].is_any = 1'b0;
      end

      assign atom_cfg[i].active = CntW'(i) < len_wide;
      assign atom_cfg[i].skip   = is_q & skip_kind;
      assign atom_cfg[i].loop   = is_q & (rlm_rep_type'(kind_ff) == REP_STAR);
      assign atom_cfg[i].plus   = is_q & (rlm_rep_type'(kind_ff) == REP_PLUS);
   end

endmodule

`default_nettype wire
